### src/mssd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mssd_pkg
// Shared types and constants for the multiplexed seven-segment driver.
// ----------------------------------------------------------------------------
package mssd_pkg;

  localparam int unsigned DIGITS   = 8;
  localparam int unsigned DIGIT_W  = 3;
  localparam int unsigned FILL_W   = 4;
  localparam int unsigned PADDR_W  = 5;
  localparam int unsigned PDATA_W  = 32;

  // Segment store after reset: dash H E L L O bang dash, digit 0 in the low byte
  localparam logic [DIGITS-1:0][7:0] STORE_INIT = 64'h0241FC1C1C9E6E02;

  localparam logic        LSB_FIRST_RST  = 1'b0;
  localparam logic [7:0]  SLOT_TICKS_RST = 8'd10;
  localparam logic [11:0] HOLD_TICKS_RST = 12'd520;
  localparam logic [15:0] BRIGHT_RST     = 16'hAAAA;
  localparam logic [7:0]  IDLE_LIMIT_RST = 8'd2;

  localparam logic [7:0]  IDLE_MAX       = 8'd255;
  localparam logic [8:0]  DIM_DARK       = 9'd256;

  typedef enum logic [2:0] {
    REG_LSB_FIRST  = 3'd0,
    REG_SLOT_TICKS = 3'd1,
    REG_HOLD_TICKS = 3'd2,
    REG_BRIGHTNESS = 3'd3,
    REG_IDLE_LIMIT = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic        lsb_first;
    logic [7:0]  slot_ticks;
    logic [11:0] hold_ticks;
    logic [15:0] digit_brightness;
    logic [7:0]  idle_limit;
  } cfg_t;

  typedef struct packed {
    logic               shift_clock;
    logic               latch_clock;
    logic [8:0]         dim_compare;
    logic [DIGIT_W-1:0] digit_index;
    logic               tx_valid;
    logic [7:0]         tx_byte;
  } res_t;

endpackage

### src/multiplexed_seven_segment_driver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multiplexed_seven_segment_driver
// Eight-digit scan driver for a one-wire shift register display chain.
//
//   channel  direction  handshake                 payload
//   in       sink       in_valid_i / in_stall_o   mode_i, rx_byte_i
//   out      source     out_valid_o / out_stall_i shift_clock_o .. tx_byte_o
//   cfg      APB slave  psel/penable/pwrite       paddr, pwdata, prdata
//
// One transaction per cycle while in_stall_o is low; a result appears in the
// cycle after acceptance, from the single result register after scan/store.
// in_stall_o is high only while a result is held and out_stall_i is high.
// Reset restores the display pattern, scan state and register defaults at once.
// ----------------------------------------------------------------------------
module multiplexed_seven_segment_driver (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mssd_pkg::PADDR_W-1:0] paddr,
  input  logic [mssd_pkg::PDATA_W-1:0] pwdata,
  output logic [mssd_pkg::PDATA_W-1:0] prdata,
  output logic                         pready,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         mode_i,
  input  logic [7:0]                   rx_byte_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         shift_clock_o,
  output logic                         latch_clock_o,
  output logic [8:0]                   dim_compare_o,
  output logic [mssd_pkg::DIGIT_W-1:0] digit_index_o,
  output logic                         tx_valid_o,
  output logic [7:0]                   tx_byte_o
);

  mssd_pkg::cfg_t cfg;
  mssd_pkg::res_t res;
  logic           out_valid_q, out_valid_d;
  logic           step;

  mssd_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign in_stall_o = out_valid_q & out_stall_i;
  assign step       = in_valid_i & ~in_stall_o;

  mssd_scan u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .step_i    (step),
    .mode_i    (mode_i),
    .rx_byte_i (rx_byte_i),
    .res_o     (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (step) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign shift_clock_o = res.shift_clock;
  assign latch_clock_o = res.latch_clock;
  assign dim_compare_o = res.dim_compare;
  assign digit_index_o = res.digit_index;
  assign tx_valid_o    = res.tx_valid;
  assign tx_byte_o     = res.tx_byte;

endmodule

### src/mssd_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mssd_regs
// APB-style configuration register file for the seven-segment driver.
// ----------------------------------------------------------------------------
module mssd_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mssd_pkg::PADDR_W-1:0] paddr,
  input  logic [mssd_pkg::PDATA_W-1:0] pwdata,
  output logic [mssd_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  output mssd_pkg::cfg_t              cfg_o
);

  mssd_pkg::cfg_t cfg_q, cfg_d;
  logic           wr_en;
  logic [2:0]     reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[4:2];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        mssd_pkg::REG_LSB_FIRST:  cfg_d.lsb_first        = pwdata[0];
        mssd_pkg::REG_SLOT_TICKS: cfg_d.slot_ticks       = pwdata[7:0];
        mssd_pkg::REG_HOLD_TICKS: cfg_d.hold_ticks       = pwdata[11:0];
        mssd_pkg::REG_BRIGHTNESS: cfg_d.digit_brightness = pwdata[15:0];
        mssd_pkg::REG_IDLE_LIMIT: cfg_d.idle_limit       = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      mssd_pkg::REG_LSB_FIRST:  prdata = {31'd0, cfg_q.lsb_first};
      mssd_pkg::REG_SLOT_TICKS: prdata = {24'd0, cfg_q.slot_ticks};
      mssd_pkg::REG_HOLD_TICKS: prdata = {20'd0, cfg_q.hold_ticks};
      mssd_pkg::REG_BRIGHTNESS: prdata = {16'd0, cfg_q.digit_brightness};
      mssd_pkg::REG_IDLE_LIMIT: prdata = {24'd0, cfg_q.idle_limit};
      default:                  prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.lsb_first        <= mssd_pkg::LSB_FIRST_RST;
      cfg_q.slot_ticks       <= mssd_pkg::SLOT_TICKS_RST;
      cfg_q.hold_ticks       <= mssd_pkg::HOLD_TICKS_RST;
      cfg_q.digit_brightness <= mssd_pkg::BRIGHT_RST;
      cfg_q.idle_limit       <= mssd_pkg::IDLE_LIMIT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### src/mssd_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mssd_scan
// Digit scan sequencer, segment store and result register.
// ----------------------------------------------------------------------------
module mssd_scan (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  mssd_pkg::cfg_t cfg_i,
  input  logic           step_i,
  input  logic           mode_i,
  input  logic [7:0]     rx_byte_i,
  output mssd_pkg::res_t res_o
);

  localparam int unsigned DW = mssd_pkg::DIGIT_W;
  localparam int unsigned FW = mssd_pkg::FILL_W;

  logic [mssd_pkg::DIGITS-1:0][7:0] store_q, store_d;
  logic [DW-1:0] digit_q, digit_d;
  logic [3:0]    bit_pos_q, bit_pos_d;
  logic [1:0]    slot_q, slot_d;
  logic [11:0]   tick_q, tick_d;
  logic          hold_q, hold_d;
  logic          line_q, line_d;
  logic [8:0]    cmp_q, cmp_d;
  logic [7:0]    idle_q, idle_d;
  logic [FW-1:0] fill_q, fill_d;
  mssd_pkg::res_t res_q, res_d;

  logic [15:0]   word;
  logic [3:0]    bit_idx;
  logic          cur_bit;
  logic [12:0]   tick_inc;
  logic [FW-1:0] fill_eff;
  logic [1:0]    bright;
  logic          latch;
  logic          txv;
  logic [7:0]    txb;

  assign word     = {store_q[digit_q], ~(8'h80 >> digit_q)};
  assign bit_idx  = cfg_i.lsb_first ? bit_pos_q : 4'd15 - bit_pos_q;
  assign cur_bit  = word[bit_idx];
  assign tick_inc = {1'b0, tick_q} + 13'd1;
  assign fill_eff = (idle_q > cfg_i.idle_limit) ? '0 : fill_q;
  assign bright   = cfg_i.digit_brightness[{digit_q, 1'b0} +: 2];

  always_comb begin
    store_d   = store_q;
    digit_d   = digit_q;
    bit_pos_d = bit_pos_q;
    slot_d    = slot_q;
    tick_d    = tick_q;
    hold_d    = hold_q;
    line_d    = line_q;
    cmp_d     = cmp_q;
    idle_d    = idle_q;
    fill_d    = fill_q;
    latch     = 1'b1;
    txv       = 1'b0;
    txb       = 8'd0;
    if (mode_i) begin
      idle_d = 8'd0;
      if (fill_eff < FW'(mssd_pkg::DIGITS)) begin
        store_d[fill_eff[DW-1:0]] = rx_byte_i;
        fill_d = fill_eff + FW'(1);
      end else begin
        fill_d = FW'(mssd_pkg::DIGITS);
        txv    = 1'b1;
        txb    = rx_byte_i;
      end
    end else if (!hold_q) begin
      line_d = !((slot_q == 2'd1) && ((tick_q == 12'd0) || !cur_bit));
      tick_d = tick_inc[11:0];
      if (tick_inc >= {5'd0, cfg_i.slot_ticks}) begin
        tick_d = '0;
        if (slot_q == 2'd2) begin
          slot_d    = '0;
          bit_pos_d = bit_pos_q + 4'd1;
          if (bit_pos_q == 4'd15) begin
            hold_d = 1'b1;
          end
        end else begin
          slot_d = slot_q + 2'd1;
        end
      end
    end else begin
      if (tick_q == 12'd0) begin
        latch = 1'b0;
        cmp_d = mssd_pkg::DIM_DARK >> {bright, 1'b0};
      end
      line_d = 1'b1;
      tick_d = tick_inc[11:0];
      if (tick_inc >= {1'b0, cfg_i.hold_ticks}) begin
        tick_d = '0;
        hold_d = 1'b0;
        if (idle_q != mssd_pkg::IDLE_MAX) begin
          idle_d = idle_q + 8'd1;
        end
        digit_d = (digit_q == DW'(mssd_pkg::DIGITS - 1)) ? '0 : digit_q + DW'(1);
      end
    end
  end

  always_comb begin
    res_d.shift_clock = line_d;
    res_d.latch_clock = latch;
    res_d.dim_compare = cmp_d;
    res_d.digit_index = digit_q;
    res_d.tx_valid    = txv;
    res_d.tx_byte     = txb;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      store_q   <= mssd_pkg::STORE_INIT;
      digit_q   <= '0;
      bit_pos_q <= '0;
      slot_q    <= '0;
      tick_q    <= '0;
      hold_q    <= 1'b0;
      line_q    <= 1'b1;
      cmp_q     <= mssd_pkg::DIM_DARK;
      idle_q    <= '0;
      fill_q    <= '0;
    end else if (step_i) begin
      store_q   <= store_d;
      digit_q   <= digit_d;
      bit_pos_q <= bit_pos_d;
      slot_q    <= slot_d;
      tick_q    <= tick_d;
      hold_q    <= hold_d;
      line_q    <= line_d;
      cmp_q     <= cmp_d;
      idle_q    <= idle_d;
      fill_q    <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FW'(mssd_pkg::DIGITS))
    else $error("fill count beyond digit count");

  a_hold_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(hold_q) |-> (bit_pos_q == 4'd0) && (slot_q == 2'd0) && (tick_q == 12'd0))
    else $error("hold entered mid word");

  a_latch_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(step_i) && !res_q.latch_clock |-> res_q.shift_clock)
    else $error("latch pulse while line low");

  a_tx_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(step_i) && !res_q.tx_valid |-> res_q.tx_byte == 8'd0)
    else $error("tx byte set without forward");

  a_dim_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmp_q == 9'd256 || cmp_q == 9'd64 || cmp_q == 9'd16 || cmp_q == 9'd4)
    else $error("illegal compare value");

endmodule
